// ===== design/jsv_pkg.sv =====
package jsv_pkg;

  // Field widths of the three channels
  localparam int unsigned TEXT_BYTE_W = 8;
  localparam int unsigned VERDICT_W   = 2;
  localparam int unsigned ERR_OFF_W   = 32;
  localparam int unsigned LIMIT_W     = 10;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd512;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_BUSY   = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_REJECT = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CTRL   = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_L   = 8'h6C;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_S   = 8'h73;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_U   = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Literal selectors
  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  // Length of each literal
  function automatic logic [2:0] lit_len(input logic [1:0] k);
    logic [2:0] n;
    case (k)
      LIT_FALSE: n = 3'd5;
      default:   n = 3'd4;
    endcase
    return n;
  endfunction

  // Letter at a given place of each literal
  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] ch;
    ch = CH_NUL;
    case (k)
      LIT_TRUE: begin
        case (idx)
          3'd0:    ch = CH_LO_T;
          3'd1:    ch = CH_LO_R;
          3'd2:    ch = CH_LO_U;
          3'd3:    ch = CH_LO_E;
          default: ch = CH_NUL;
        endcase
      end
      LIT_FALSE: begin
        case (idx)
          3'd0:    ch = CH_LO_F;
          3'd1:    ch = CH_LO_A;
          3'd2:    ch = CH_LO_L;
          3'd3:    ch = CH_LO_S;
          3'd4:    ch = CH_LO_E;
          default: ch = CH_NUL;
        endcase
      end
      LIT_NULL: begin
        case (idx)
          3'd0:    ch = CH_LO_N;
          3'd1:    ch = CH_LO_U;
          3'd2:    ch = CH_LO_L;
          3'd3:    ch = CH_LO_L;
          default: ch = CH_NUL;
        endcase
      end
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

// ===== design/jsv_ifs.sv =====
// Text byte channel
interface jsv_text_if import jsv_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [TEXT_BYTE_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// Result channel
interface jsv_result_if import jsv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [ERR_OFF_W-1:0] error_offset;
  logic                 text_done;

  modport source (output valid, output verdict, output error_offset, output text_done,
                  input ready);
  modport sink   (input valid, input verdict, input error_offset, input text_done,
                  output ready);
endinterface

// Configuration write channel
interface jsv_cfg_if import jsv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] nesting_limit;

  modport source (output valid, output nesting_limit, input ready);
  modport sink   (input valid, input nesting_limit, output ready);
endinterface

// ===== design/json_syntax_validator.sv =====
// Streaming JSON syntax checker. Text enters one byte per word on text_i, a zero
// byte ending each text; every byte yields one result word on result_o with the
// verdict so far (busy, accepted on the terminator, or rejected with the offset of
// the first error). One byte is taken every clock cycle when the result side keeps
// up; a byte's result word is registered: the byte is held in an input register,
// passes through the mode logic, which reads the top-of-stack register, and its
// word is held in the result register until the result side takes it.
// The container stack is a MAX_NESTING x 1 memory with one write and one registered
// read port, read one level below the top so that a close finds the new top ready.
// nesting_limit on cfg_i may be written only between texts or while idle.
module json_syntax_validator import jsv_pkg::*; #(
  parameter int unsigned MAX_NESTING = 512,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  jsv_text_if.sink      text_i,
  jsv_result_if.source  result_o,
  jsv_cfg_if.sink       cfg_i
);

  localparam int unsigned DEPTH_W = $clog2(MAX_NESTING + 1);
  localparam int unsigned IDX_W   = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  typedef enum logic [4:0] {
    M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_KEY, M_COLON, M_AFTER,
    M_STR_V, M_ESC_V, M_HEX_V, M_STR_K, M_ESC_K, M_HEX_K,
    M_LIT_T, M_LIT_F, M_LIT_N,
    M_NUM_SIGN, M_NUM_ZERO, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC,
    M_NUM_E, M_NUM_ESIGN, M_NUM_EXP, M_DEAD
  } mode_e;

  // Registers
  logic [LIMIT_W-1:0]     limit_q;
  logic                   in_v_q;
  logic [7:0]             byte_q;
  mode_e                  mode_q, mode_d;
  logic [DEPTH_W-1:0]     depth_q, depth_d, depth_nx;
  logic                   top_q, top_d;
  logic                   below_q;
  logic [OFFSET_BITS-1:0] pos_q, tok_q, tok_d, err_q, err_d;
  logic [2:0]             sub_q, sub_d;
  logic                   failed_q, failed_d;
  logic                   out_v_q;
  logic [VERDICT_W-1:0]   verdict_q;
  logic [ERR_OFF_W-1:0]   err_off_q;
  logic                   done_q;
  logic                   stack_mem [MAX_NESTING];

  // Combinational working signals
  logic                   adv, is_end;
  logic                   do_value, do_after, fail_en, push_en, push_bit;
  logic [OFFSET_BITS-1:0] fail_off, pos_inc;
  logic [31:0]            lim_eff;
  logic [1:0]             lit_k;
  logic [2:0]             sub_inc;
  logic                   keyed;
  logic [DEPTH_W-1:0]     rd_depth;
  logic [63:0]            err_wide;
  logic [VERDICT_W-1:0]   verdict_d;

  // Handshakes: process the held byte when the result register is free
  assign adv          = in_v_q && (!out_v_q || result_o.ready);
  assign text_i.ready = !in_v_q || adv;
  assign cfg_i.ready  = 1'b1;
  assign is_end       = (byte_q == CH_NUL);
  assign pos_inc      = pos_q + 1'b1;

  assign result_o.valid        = out_v_q;
  assign result_o.verdict      = verdict_q;
  assign result_o.error_offset = err_off_q;
  assign result_o.text_done    = done_q;

  // Clamp the configured limit to the stack size
  always_comb begin
    if (32'(limit_q) > 32'(MAX_NESTING)) begin
      lim_eff = 32'(MAX_NESTING);
    end else begin
      lim_eff = 32'(limit_q);
    end
  end

  // Mode machine: one byte, with at most one hand-on to the value or after step
  always_comb begin
    mode_d   = mode_q;
    depth_d  = depth_q;
    top_d    = top_q;
    tok_d    = tok_q;
    sub_d    = sub_q;
    failed_d = failed_q;
    err_d    = err_q;
    do_value = 1'b0;
    do_after = 1'b0;
    fail_en  = 1'b0;
    fail_off = pos_q;
    push_en  = 1'b0;
    push_bit = 1'b0;
    keyed    = (mode_q == M_STR_K) || (mode_q == M_ESC_K) || (mode_q == M_HEX_K);
    sub_inc  = sub_q + 3'd1;
    lit_k    = LIT_TRUE;

    case (mode_q)
      M_VALUE: begin
        do_value = 1'b1;
      end
      M_ARR_FIRST: begin
        if (!is_ws(byte_q)) begin
          if (byte_q == CH_RBRACK) begin
            if (depth_q != '0) depth_d = depth_q - 1'b1;
            top_d  = below_q;
            mode_d = M_AFTER;
          end else begin
            tok_d    = pos_q;
            do_value = 1'b1;
          end
        end
      end
      M_OBJ_FIRST, M_KEY: begin
        if (!is_ws(byte_q)) begin
          if ((mode_q == M_OBJ_FIRST) && (byte_q == CH_RBRACE)) begin
            if (depth_q != '0) depth_d = depth_q - 1'b1;
            top_d  = below_q;
            mode_d = M_AFTER;
          end else if (byte_q == CH_QUOTE) begin
            mode_d = M_STR_K;
          end else begin
            fail_en = 1'b1;
          end
        end
      end
      M_COLON: begin
        if (!is_ws(byte_q)) begin
          if (byte_q == CH_COLON) begin
            tok_d  = pos_inc;
            mode_d = M_VALUE;
          end else begin
            fail_en = 1'b1;
          end
        end
      end
      M_AFTER: begin
        do_after = 1'b1;
      end
      M_STR_V, M_STR_K: begin
        if (byte_q < CH_CTRL) begin
          fail_en = 1'b1;
        end else if (byte_q == CH_QUOTE) begin
          mode_d = keyed ? M_COLON : M_AFTER;
        end else if (byte_q == CH_BSLASH) begin
          mode_d = keyed ? M_ESC_K : M_ESC_V;
        end
      end
      M_ESC_V, M_ESC_K: begin
        if ((byte_q == CH_QUOTE) || (byte_q == CH_BSLASH) || (byte_q == CH_SLASH) ||
            (byte_q == CH_LO_B) || (byte_q == CH_LO_F) || (byte_q == CH_LO_N) ||
            (byte_q == CH_LO_R) || (byte_q == CH_LO_T)) begin
          mode_d = keyed ? M_STR_K : M_STR_V;
        end else if (byte_q == CH_LO_U) begin
          sub_d  = 3'd0;
          mode_d = keyed ? M_HEX_K : M_HEX_V;
        end else begin
          fail_en = 1'b1;
        end
      end
      M_HEX_V, M_HEX_K: begin
        if (!is_hex(byte_q)) begin
          fail_en = 1'b1;
        end else begin
          sub_d = sub_inc;
          if (sub_inc >= 3'd4) mode_d = keyed ? M_STR_K : M_STR_V;
        end
      end
      M_LIT_T, M_LIT_F, M_LIT_N: begin
        case (mode_q)
          M_LIT_F: lit_k = LIT_FALSE;
          M_LIT_N: lit_k = LIT_NULL;
          default: lit_k = LIT_TRUE;
        endcase
        if ((sub_q < lit_len(lit_k)) && (byte_q == lit_char(lit_k, sub_q))) begin
          sub_d = sub_inc;
          if (sub_inc >= lit_len(lit_k)) mode_d = M_AFTER;
        end else begin
          fail_en  = 1'b1;
          fail_off = tok_q;
        end
      end
      M_NUM_SIGN: begin
        if (byte_q == CH_ZERO) begin
          mode_d = M_NUM_ZERO;
        end else if (is_digit(byte_q)) begin
          mode_d = M_NUM_INT;
        end else begin
          fail_en = 1'b1;
        end
      end
      M_NUM_ZERO, M_NUM_INT: begin
        if ((mode_q == M_NUM_INT) && is_digit(byte_q)) begin
          mode_d = M_NUM_INT;
        end else if (byte_q == CH_DOT) begin
          mode_d = M_NUM_DOT;
        end else if ((byte_q == CH_LO_E) || (byte_q == CH_UP_E)) begin
          mode_d = M_NUM_E;
        end else begin
          do_after = 1'b1;
        end
      end
      M_NUM_DOT: begin
        if (is_digit(byte_q)) mode_d = M_NUM_FRAC;
        else fail_en = 1'b1;
      end
      M_NUM_FRAC: begin
        if (is_digit(byte_q)) begin
          mode_d = M_NUM_FRAC;
        end else if ((byte_q == CH_LO_E) || (byte_q == CH_UP_E)) begin
          mode_d = M_NUM_E;
        end else begin
          do_after = 1'b1;
        end
      end
      M_NUM_E: begin
        if ((byte_q == CH_PLUS) || (byte_q == CH_MINUS)) begin
          mode_d = M_NUM_ESIGN;
        end else if (is_digit(byte_q)) begin
          mode_d = M_NUM_EXP;
        end else begin
          fail_en = 1'b1;
        end
      end
      M_NUM_ESIGN: begin
        if (is_digit(byte_q)) mode_d = M_NUM_EXP;
        else fail_en = 1'b1;
      end
      M_NUM_EXP: begin
        if (!is_digit(byte_q)) do_after = 1'b1;
      end
      default: begin
        mode_d = mode_q;
      end
    endcase

    // Value expected: depth check first, then the opening byte
    if (do_value) begin
      if (32'(depth_q) >= lim_eff) begin
        fail_en  = 1'b1;
        fail_off = tok_d;
      end else if (!is_ws(byte_q)) begin
        tok_d = pos_q;
        sub_d = 3'd1;
        case (byte_q)
          CH_LBRACE: begin
            push_en  = 1'b1;
            push_bit = 1'b1;
            mode_d   = M_OBJ_FIRST;
          end
          CH_LBRACK: begin
            push_en  = 1'b1;
            push_bit = 1'b0;
            mode_d   = M_ARR_FIRST;
          end
          CH_QUOTE: mode_d = M_STR_V;
          CH_LO_T:  mode_d = M_LIT_T;
          CH_LO_F:  mode_d = M_LIT_F;
          CH_LO_N:  mode_d = M_LIT_N;
          CH_MINUS: mode_d = M_NUM_SIGN;
          CH_ZERO:  mode_d = M_NUM_ZERO;
          default: begin
            if (is_digit(byte_q)) mode_d = M_NUM_INT;
            else fail_en = 1'b1;
          end
        endcase
        if (push_en) begin
          depth_d = depth_q + 1'b1;
          top_d   = push_bit;
        end
      end
    end

    // After a value: separator, close or end of text
    if (do_after) begin
      mode_d = M_AFTER;
      if (!is_ws(byte_q)) begin
        if (depth_q == '0) begin
          if (!is_end) fail_en = 1'b1;
        end else if (byte_q == CH_COMMA) begin
          if (top_q) begin
            mode_d = M_KEY;
          end else begin
            tok_d  = pos_inc;
            mode_d = M_VALUE;
          end
        end else if ((top_q && (byte_q == CH_RBRACE)) ||
                     (!top_q && (byte_q == CH_RBRACK))) begin
          depth_d = depth_q - 1'b1;
          top_d   = below_q;
        end else begin
          fail_en = 1'b1;
        end
      end
    end

    // Record the first error and stop parsing
    if (fail_en) begin
      failed_d = 1'b1;
      err_d    = fail_off;
      mode_d   = M_DEAD;
      push_en  = 1'b0;
      depth_d  = depth_q;
      top_d    = top_q;
    end
  end

  // Result word of this byte
  always_comb begin
    err_wide = failed_d ? 64'(err_d) : 64'd0;
    if (failed_d) begin
      verdict_d = VERDICT_REJECT;
    end else if (is_end) begin
      verdict_d = VERDICT_ACCEPT;
    end else begin
      verdict_d = VERDICT_BUSY;
    end
  end

  // Depth after this cycle, for the below-top read address
  always_comb begin
    if (adv) begin
      depth_nx = is_end ? '0 : depth_d;
    end else begin
      depth_nx = depth_q;
    end
    rd_depth = depth_nx - DEPTH_W'(2);
  end

  // Stack memory: write on open, read the level below the next top
  always_ff @(posedge clk_i) begin
    if (adv && push_en) begin
      stack_mem[depth_q[IDX_W-1:0]] <= push_bit;
    end
    if (depth_nx >= DEPTH_W'(2)) begin
      below_q <= stack_mem[rd_depth[IDX_W-1:0]];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (text_i.valid && text_i.ready) begin
      byte_q <= text_i.text_byte;
    end
    if (adv) begin
      verdict_q <= verdict_d;
      err_off_q <= err_wide[ERR_OFF_W-1:0];
      done_q    <= is_end;
    end
  end

  // Control and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RESET;
      in_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      mode_q   <= M_VALUE;
      depth_q  <= '0;
      top_q    <= 1'b0;
      pos_q    <= '0;
      tok_q    <= '0;
      sub_q    <= '0;
      failed_q <= 1'b0;
      err_q    <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        limit_q <= cfg_i.nesting_limit;
      end

      if (text_i.valid && text_i.ready) begin
        in_v_q <= 1'b1;
      end else if (adv) begin
        in_v_q <= 1'b0;
      end

      if (adv) begin
        out_v_q <= 1'b1;
      end else if (result_o.ready) begin
        out_v_q <= 1'b0;
      end

      if (adv) begin
        if (is_end) begin
          // Terminator: start the next text afresh
          mode_q   <= M_VALUE;
          depth_q  <= '0;
          top_q    <= 1'b0;
          pos_q    <= '0;
          tok_q    <= '0;
          sub_q    <= '0;
          failed_q <= 1'b0;
          err_q    <= '0;
        end else begin
          mode_q   <= mode_d;
          depth_q  <= depth_d;
          top_q    <= top_d;
          pos_q    <= pos_inc;
          tok_q    <= tok_d;
          sub_q    <= sub_d;
          failed_q <= failed_d;
          err_q    <= err_d;
        end
      end
    end
  end

endmodule

// ===== design/jsv_checker.sv =====
module jsv_checker import jsv_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 res_valid_i,
  input logic                 res_ready_i,
  input logic [VERDICT_W-1:0] verdict_i,
  input logic [ERR_OFF_W-1:0] error_offset_i,
  input logic                 text_done_i
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(verdict_i) &&
    $stable(error_offset_i) && $stable(text_done_i))
    else $error("result word changed while stalled");

  // Acceptance only on the terminator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (verdict_i == VERDICT_ACCEPT) |-> text_done_i)
    else $error("text accepted before its terminator");

  // The terminator always settles the verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && text_done_i |-> (verdict_i == VERDICT_ACCEPT) ||
    (verdict_i == VERDICT_REJECT))
    else $error("terminator left the verdict open");

  // No error offset unless rejected
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (verdict_i != VERDICT_REJECT) |-> (error_offset_i == '0))
    else $error("error offset shown without a rejection");

endmodule

bind json_syntax_validator jsv_checker u_jsv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (result_o.valid),
  .res_ready_i    (result_o.ready),
  .verdict_i      (result_o.verdict),
  .error_offset_i (result_o.error_offset),
  .text_done_i    (result_o.text_done)
);
